### rtl/bbcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcl_pkg: shared types and constants of the buffer cache LRU unit
// Slot entry layout, command and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bbcl_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam int SLOT_W  = 5;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int STAMP_W = 32;
	localparam int REFS_W  = 8;
	localparam int CMD_W   = 2;
	localparam int STS_W   = 2;

	localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;

	// command codes
	localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNPIN = 2'd2;

	// status codes
	localparam logic [STS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STS_W-1:0] ST_ERR  = 2'd2;

	// one slot of the tag store
	typedef struct packed {
		logic [DEV_W-1:0]   dev;
		logic [BLK_W-1:0]   blk;
		logic [STAMP_W-1:0] stamp;
		logic [REFS_W-1:0]  refs;
		logic               assigned;
		logic               data_valid;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture the input word, clear scan results
		logic scan_rd;  // read slot at scan counter, advance counter
		logic slot_rd;  // read slot addressed by slot_index
		logic finish;   // update the store and drive the result
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last; // scan counter is on the last slot
	} sts_t;

endpackage

### rtl/bbcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcl_ctrl: sequencer of the buffer cache LRU unit
// Steps a get through a full scan of the slot store, a pin or unpin through
// one slot read (a reserved code skips both), then has the datapath finish.
// ----------------------------------------------------------------------------
module bbcl_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bbcl_pkg::CMD_W-1:0] command,
	input  bbcl_pkg::sts_t            sts,
	output bbcl_pkg::ctl_t            ctl,
	output logic                      busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SLOT_RD,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;

	// state and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						unique case (command) inside
							bbcl_pkg::CMD_GET:                      state_q <= S_SCAN;
							bbcl_pkg::CMD_PIN, bbcl_pkg::CMD_UNPIN: state_q <= S_SLOT_RD;
							default:                                state_q <= S_FINISH;
						endcase
					end
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_SLOT_RD: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		ctl         = '0;
		ctl.load    = (state_q == S_IDLE) && start;
		ctl.scan_rd = (state_q == S_SCAN);
		ctl.slot_rd = (state_q == S_SLOT_RD);
		ctl.finish  = (state_q == S_FINISH);
	end

	assign busy = busy_q;

	// busy tracks the non-idle states
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	// a scan always ends through the drain step
	a_scan_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && sts.scan_last |=> (state_q == S_DRAIN))
		else $error("scan did not drain");

	// finish returns to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> (state_q == S_IDLE) && !busy_q)
		else $error("finish did not return to idle");

endmodule

### rtl/bbcl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcl_dp: slot store and datapath of the buffer cache LRU unit
// Single-port slot memory with per-slot valid bits, tag match and oldest
// free slot search over a sequential scan, count update and result registers.
// ----------------------------------------------------------------------------
module bbcl_dp #(
	parameter int ENTRIES = bbcl_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbcl_pkg::ctl_t                ctl,
	output bbcl_pkg::sts_t                sts,
	input  logic [bbcl_pkg::CMD_W-1:0]    command,
	input  logic [bbcl_pkg::DEV_W-1:0]    device,
	input  logic [bbcl_pkg::BLK_W-1:0]    block_number,
	input  logic [bbcl_pkg::SLOT_W-1:0]   slot_index,
	input  logic [bbcl_pkg::STAMP_W-1:0]  now,
	output logic                          done,
	output logic [bbcl_pkg::SLOT_W-1:0]   result_slot,
	output logic                          hit,
	output logic                          fill_needed,
	output logic [bbcl_pkg::STS_W-1:0]    status
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// captured input word
	logic [bbcl_pkg::CMD_W-1:0]   cmd_q;
	logic [bbcl_pkg::DEV_W-1:0]   dev_q;
	logic [bbcl_pkg::BLK_W-1:0]   blk_q;
	logic [bbcl_pkg::SLOT_W-1:0]  idx_q;
	logic [bbcl_pkg::STAMP_W-1:0] now_q;

	// slot store
	bbcl_pkg::entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;

	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	bbcl_pkg::entry_t   rd_s1;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_addr_s1;
	logic               eval_s1;

	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	bbcl_pkg::entry_t   wr_data;

	// scan state
	logic [IW-1:0]               cnt_q;
	logic                        match_q;
	logic [IW-1:0]               match_idx_q;
	logic [bbcl_pkg::REFS_W-1:0] match_refs_q;
	logic                        match_dv_q;
	logic                        found_q;
	logic [IW-1:0]               pick_q;
	logic [bbcl_pkg::STAMP_W-1:0] best_q;

	// evaluation of the slot just read
	bbcl_pkg::entry_t ev;
	logic             ev_match;
	logic             ev_free;

	// finish results
	logic [IW-1:0]                idx_addr;
	logic                         in_range;
	logic [bbcl_pkg::SLOT_W-1:0]  o_slot;
	logic                         o_hit;
	logic                         o_fill;
	logic [bbcl_pkg::STS_W-1:0]   o_status;

	// output registers
	logic                         done_q;
	logic [bbcl_pkg::SLOT_W-1:0]  result_slot_q;
	logic                         hit_q;
	logic                         fill_q;
	logic [bbcl_pkg::STS_W-1:0]   status_q;

	assign idx_addr      = IW'(idx_q);
	assign in_range      = (32'(idx_q) < 32'(ENTRIES));
	assign sts.scan_last = (cnt_q == LAST_IDX);

	// input capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			dev_q <= device;
			blk_q <= block_number;
			idx_q <= slot_index;
			now_q <= now;
		end
	end

	// read port address select
	assign rd_en   = ctl.scan_rd || ctl.slot_rd;
	assign rd_addr = ctl.scan_rd ? cnt_q : idx_addr;

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// valid bits, read tag and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
			eval_s1    <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1  <= vld_q[rd_addr];
				rd_addr_s1 <= rd_addr;
			end
			eval_s1 <= ctl.scan_rd;
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.scan_rd) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	// a never-written slot reads as the reset value
	always_comb begin
		ev       = rd_vld_s1 ? rd_s1 : '0;
		ev_match = ev.assigned && (ev.dev == dev_q) && (ev.blk == blk_q);
		ev_free  = (ev.refs == '0) && (!found_q || (ev.stamp < best_q));
	end

	// first match and oldest unreferenced slot, lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.load) begin
			match_q <= 1'b0;
			found_q <= 1'b0;
		end else if (eval_s1) begin
			if (!match_q && ev_match) begin
				match_q <= 1'b1;
			end
			if (ev_free) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_s1) begin
			if (!match_q && ev_match) begin
				match_idx_q  <= rd_addr_s1;
				match_refs_q <= ev.refs;
				match_dv_q   <= ev.data_valid;
			end
			if (ev_free) begin
				pick_q <= rd_addr_s1;
				best_q <= ev.stamp;
			end
		end
	end

	// store update and result of the finishing word
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_addr;
		wr_data  = ev;
		o_slot   = '0;
		o_hit    = 1'b0;
		o_fill   = 1'b0;
		o_status = bbcl_pkg::ST_ERR;
		case (cmd_q)
			bbcl_pkg::CMD_GET: begin
				wr_data.dev        = dev_q;
				wr_data.blk        = blk_q;
				wr_data.stamp      = now_q;
				wr_data.assigned   = 1'b1;
				wr_data.data_valid = 1'b1;
				if (match_q) begin
					wr_en        = ctl.finish;
					wr_addr      = match_idx_q;
					wr_data.refs = (match_refs_q == bbcl_pkg::REFS_MAX) ?
						match_refs_q : match_refs_q + 8'd1;
					o_slot   = bbcl_pkg::SLOT_W'(match_idx_q);
					o_hit    = 1'b1;
					o_fill   = !match_dv_q;
					o_status = bbcl_pkg::ST_OK;
				end else if (found_q) begin
					wr_en        = ctl.finish;
					wr_addr      = pick_q;
					wr_data.refs = 8'd1;
					o_slot   = bbcl_pkg::SLOT_W'(pick_q);
					o_fill   = 1'b1;
					o_status = bbcl_pkg::ST_OK;
				end else begin
					o_status = bbcl_pkg::ST_FULL;
				end
			end
			bbcl_pkg::CMD_PIN: begin
				o_slot = idx_q;
				if (in_range) begin
					wr_en        = ctl.finish;
					wr_data.refs = (ev.refs == bbcl_pkg::REFS_MAX) ?
						ev.refs : ev.refs + 8'd1;
					o_status = bbcl_pkg::ST_OK;
				end
			end
			bbcl_pkg::CMD_UNPIN: begin
				o_slot = idx_q;
				if (in_range && (ev.refs != '0)) begin
					wr_en        = ctl.finish;
					wr_data.refs = ev.refs - 8'd1;
					o_status = bbcl_pkg::ST_OK;
				end
			end
			default: begin
				o_status = bbcl_pkg::ST_ERR;
			end
		endcase
	end

	// result registers, strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			result_slot_q <= o_slot;
			hit_q         <= o_hit;
			fill_q        <= o_fill;
			status_q      <= o_status;
		end
	end

	assign done        = done_q;
	assign result_slot = result_slot_q;
	assign hit         = hit_q;
	assign fill_needed = fill_q;
	assign status      = status_q;

	// a hit is always a good get
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && hit_q |-> (status_q == bbcl_pkg::ST_OK))
		else $error("hit reported with error status");

	// full cache reports nothing else
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == bbcl_pkg::ST_FULL) |->
			!hit_q && !fill_q && (result_slot_q == '0))
		else $error("full status with slot data");

	// the store is written only while finishing
	a_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ctl.finish && !rd_en)
		else $error("store write outside finish");

endmodule

### rtl/block_buffer_cache_lru_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_unit: buffer cache tag and LRU replacement engine
// Get looks up a device/block pair and on a miss retags the oldest
// unreferenced slot; pin and unpin adjust a slot's reference count.
//
//   channel  | handshake          | word
//   ---------+--------------------+-------------------------------------------
//   request  | start, busy        | command, device, block_number,
//            |                    | slot_index, now
//   result   | done (strobe)      | result_slot, hit, fill_needed, status
//
// A word is taken at a clock edge with start high and busy low.
// Get scans the single-port slot store one slot per cycle, then drains and
// finishes; pin/unpin reads one slot, then finishes; reserved only finishes.
// The result shows as busy falls, for one cycle, with done high;
// a new word may be taken in that same cycle.
// Reset clears all slots at once through per-slot valid bits; no sweep.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_unit #(
	parameter int ENTRIES = bbcl_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bbcl_pkg::CMD_W-1:0]    command,
	input  logic [bbcl_pkg::DEV_W-1:0]    device,
	input  logic [bbcl_pkg::BLK_W-1:0]    block_number,
	input  logic [bbcl_pkg::SLOT_W-1:0]   slot_index,
	input  logic [bbcl_pkg::STAMP_W-1:0]  now,
	output logic                          done,
	output logic [bbcl_pkg::SLOT_W-1:0]   result_slot,
	output logic                          hit,
	output logic                          fill_needed,
	output logic [bbcl_pkg::STS_W-1:0]    status
);

	bbcl_pkg::ctl_t ctl;
	bbcl_pkg::sts_t sts;

	// sequencer
	bbcl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	// slot store and datapath
	bbcl_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.device       (device),
		.block_number (block_number),
		.slot_index   (slot_index),
		.now          (now),
		.done         (done),
		.result_slot  (result_slot),
		.hit          (hit),
		.fill_needed  (fill_needed),
		.status       (status)
	);

endmodule
